### sv/skts_pkg.sv
// shared constants, codes and controller/datapath types for the sorted key table seek core
package skts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_W       = 10;
    localparam int PROBE_W     = 11;
    localparam int IN_KEY_W    = 64;
    localparam int SCAN_LIMIT  = 3;

    localparam logic [PROBE_W-1:0]   COUNT_MAX = '1;
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN  = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_SIGNED     = 2'd0,
        CFG_PERMISSIVE = 2'd1,
        CFG_SEQUENTIAL = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ROW_ZERO,
        ROW_APPEND,
        ROW_SCAN,
        ROW_HI
    } t_row_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_BIN_EVAL,
        S_SCAN_CHECK,
        S_SCAN_EVAL
    } t_state;

    typedef struct packed {
        logic     load;
        logic     clear_table;
        logic     append;
        logic     bin_latch;
        logic     bin_update;
        logic     scan_init;
        logic     scan_step;
        logic     addr_scan;
        logic     count_inc;
        logic     finish;
        t_status  res_status;
        t_row_sel res_row;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    table_full;
        logic    wide;
        logic    scan_end;
        logic    hi_at_end;
        logic    cmp_eq;
        logic    cmp_gt;
        logic    seq_mode;
        logic    permissive;
    } t_dp_stat;

endpackage

### sv/skts_ram.sv
// generic single-write, single-read ram with registered read data
module skts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/skts_dp.sv
// datapath: config bits, key table, search bounds, comparator and result registers
module skts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [0:0]                    i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [skts_pkg::IN_KEY_W-1:0] i_key_value,
    input  skts_pkg::t_dp_cmd             i_cmd,
    output skts_pkg::t_dp_stat            o_stat,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [skts_pkg::ROW_W-1:0]    o_row_index,
    output logic [skts_pkg::PROBE_W-1:0]  o_compare_count
);

    localparam int KW = skts_pkg::KEY_WIDTH;
    localparam int CW = skts_pkg::CNT_W;
    localparam int AW = skts_pkg::ADDR_W;

    logic [KW-1:0]                  r_key, n_key;
    skts_pkg::t_action              r_action, n_action;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_lo, n_lo;
    logic [CW-1:0]                  r_hi, n_hi;
    logic [CW-1:0]                  r_idx, n_idx;
    logic [CW-1:0]                  r_mid, n_mid;
    logic [skts_pkg::PROBE_W-1:0]   r_probes, n_probes;
    logic                           r_signed, n_signed;
    logic                           r_permissive, n_permissive;
    logic                           r_seq, n_seq;
    logic                           r_valid, n_valid;
    skts_pkg::t_status              r_status, n_status;
    logic [skts_pkg::ROW_W-1:0]     r_row, n_row;

    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_w;
    logic [CW-1:0]  span;
    logic [KW-1:0]  rdata;
    logic [KW-1:0]  cmp_a;
    logic [KW-1:0]  cmp_b;
    logic [KW-1:0]  sign_flip;
    logic [AW-1:0]  raddr;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_w     = mid_sum[CW:1];
    assign span      = r_hi - r_lo;
    assign sign_flip = r_signed ? skts_pkg::KEY_SIGN : '0;
    assign cmp_a     = rdata ^ sign_flip;
    assign cmp_b     = r_key ^ sign_flip;
    assign raddr     = i_cmd.addr_scan ? r_idx[AW-1:0] : mid_w[AW-1:0];

    skts_ram #(
        .WIDTH (KW),
        .DEPTH (skts_pkg::TABLE_DEPTH)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_stat.action     = r_action;
        o_stat.table_full = (r_count == CW'(skts_pkg::TABLE_DEPTH));
        o_stat.wide       = (span > CW'(skts_pkg::SCAN_LIMIT));
        o_stat.scan_end   = (r_idx == r_hi);
        o_stat.hi_at_end  = (r_hi == r_count);
        o_stat.cmp_eq     = (cmp_a == cmp_b);
        o_stat.cmp_gt     = (cmp_a > cmp_b);
        o_stat.seq_mode   = r_seq;
        o_stat.permissive = r_permissive;
    end

    always_comb begin
        n_key        = r_key;
        n_action     = r_action;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_idx        = r_idx;
        n_mid        = r_mid;
        n_probes     = r_probes;
        n_signed     = r_signed;
        n_permissive = r_permissive;
        n_seq        = r_seq;
        n_valid      = i_cmd.finish;
        n_status     = r_status;
        n_row        = r_row;

        if (i_cmd.load) begin
            n_key    = i_key_value[KW-1:0];
            n_action = skts_pkg::t_action'(i_action);
            n_lo     = '0;
            n_hi     = r_count;
            n_probes = '0;
        end
        if (i_cmd.clear_table) begin
            n_count = '0;
        end
        if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.bin_latch) begin
            n_mid = mid_w;
        end
        // lower bound step: keep hi on a row at or above the key
        if (i_cmd.bin_update) begin
            if (o_stat.cmp_eq || o_stat.cmp_gt) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid;
            end
        end
        if (i_cmd.scan_init) begin
            n_idx = r_lo;
        end
        if (i_cmd.scan_step) begin
            n_idx = r_idx + 1'b1;
        end
        if (i_cmd.count_inc && (r_probes != skts_pkg::COUNT_MAX)) begin
            n_probes = r_probes + 1'b1;
        end
        if (i_cmd.finish) begin
            n_status = i_cmd.res_status;
            case (i_cmd.res_row)
                skts_pkg::ROW_APPEND: n_row = skts_pkg::ROW_W'(r_count);
                skts_pkg::ROW_SCAN:   n_row = skts_pkg::ROW_W'(r_idx);
                skts_pkg::ROW_HI:     n_row = skts_pkg::ROW_W'(r_hi);
                default:              n_row = '0;
            endcase
        end

        if (i_cfg_we) begin
            case (skts_pkg::t_cfg_index'(i_cfg_index))
                skts_pkg::CFG_SIGNED:     n_signed     = i_cfg_data[0];
                skts_pkg::CFG_PERMISSIVE: n_permissive = i_cfg_data[0];
                skts_pkg::CFG_SEQUENTIAL: n_seq        = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_signed     <= 1'b0;
            r_permissive <= 1'b0;
            r_seq        <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_signed     <= n_signed;
            r_permissive <= n_permissive;
            r_seq        <= n_seq;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_action <= n_action;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_idx    <= n_idx;
        r_mid    <= n_mid;
        r_probes <= n_probes;
        r_status <= n_status;
        r_row    <= n_row;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_row_index     = r_row;
    assign o_compare_count = r_probes;

endmodule

### sv/skts_ctrl.sv
// controller state machine sequencing clear, append and search transactions
module skts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  skts_pkg::t_dp_stat i_stat,
    output skts_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    skts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        case (r_state)
            skts_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = skts_pkg::S_EXEC;
                end
            end

            skts_pkg::S_EXEC: begin
                n_state = skts_pkg::S_IDLE;
                case (i_stat.action)
                    skts_pkg::ACT_CLEAR: begin
                        o_cmd.clear_table = 1'b1;
                        o_cmd.finish      = 1'b1;
                        o_cmd.res_status  = skts_pkg::ST_OK;
                        o_cmd.res_row     = skts_pkg::ROW_ZERO;
                    end
                    skts_pkg::ACT_APPEND: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.table_full) begin
                            o_cmd.res_status = skts_pkg::ST_FULL;
                            o_cmd.res_row    = skts_pkg::ROW_ZERO;
                        end else begin
                            o_cmd.append     = 1'b1;
                            o_cmd.res_status = skts_pkg::ST_OK;
                            o_cmd.res_row    = skts_pkg::ROW_APPEND;
                        end
                    end
                    skts_pkg::ACT_SEARCH: begin
                        n_state = skts_pkg::S_SEARCH;
                    end
                    default: begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.res_status = skts_pkg::ST_NOT_FOUND;
                        o_cmd.res_row    = skts_pkg::ROW_ZERO;
                    end
                endcase
            end

            // ram is addressed at the midpoint here
            skts_pkg::S_SEARCH: begin
                if (!i_stat.seq_mode && i_stat.wide) begin
                    o_cmd.bin_latch = 1'b1;
                    n_state         = skts_pkg::S_BIN_EVAL;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = skts_pkg::S_SCAN_CHECK;
                end
            end

            skts_pkg::S_BIN_EVAL: begin
                o_cmd.bin_update = 1'b1;
                o_cmd.count_inc  = 1'b1;
                n_state          = skts_pkg::S_SEARCH;
            end

            skts_pkg::S_SCAN_CHECK: begin
                o_cmd.addr_scan = 1'b1;
                if (i_stat.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = skts_pkg::S_IDLE;
                    if (i_stat.seq_mode || i_stat.hi_at_end) begin
                        o_cmd.res_status = skts_pkg::ST_NOT_FOUND;
                        o_cmd.res_row    = skts_pkg::ROW_ZERO;
                    end else begin
                        o_cmd.res_status = skts_pkg::ST_OK;
                        o_cmd.res_row    = skts_pkg::ROW_HI;
                    end
                end else begin
                    n_state = skts_pkg::S_SCAN_EVAL;
                end
            end

            skts_pkg::S_SCAN_EVAL: begin
                o_cmd.count_inc = 1'b1;
                o_cmd.addr_scan = 1'b1;
                if (i_stat.cmp_eq) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.res_status = skts_pkg::ST_OK;
                    o_cmd.res_row    = skts_pkg::ROW_SCAN;
                    n_state          = skts_pkg::S_IDLE;
                end else if (i_stat.cmp_gt && !i_stat.seq_mode) begin
                    o_cmd.finish = 1'b1;
                    n_state      = skts_pkg::S_IDLE;
                    if (i_stat.permissive) begin
                        o_cmd.res_status = skts_pkg::ST_OK;
                        o_cmd.res_row    = skts_pkg::ROW_SCAN;
                    end else begin
                        o_cmd.res_status = skts_pkg::ST_NOT_FOUND;
                        o_cmd.res_row    = skts_pkg::ROW_ZERO;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = skts_pkg::S_SCAN_CHECK;
                end
            end

            default: begin
                n_state = skts_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != skts_pkg::S_IDLE);

endmodule

### sv/sorted_key_table_seek_core.sv
// top level of the sorted key table seek core: controller, datapath and checks
//
// command channel: a transaction is taken at a rising edge with start high and
// busy low; i_action selects clear, append or search, i_key_value carries the key
// result channel: o_valid is high for exactly one cycle per transaction with
// o_status, o_row_index and o_compare_count; there is no way to hold it off
// config: i_cfg_we writes i_cfg_data to the register chosen by i_cfg_index
// (0 signed compare, 1 permissive match, 2 sequential mode), taken at once
// clear, append and unknown actions finish in the exec state that follows the load
// search: each key comparison addresses the registered-read key ram in one state
// and compares in another; a search also has its own steps to load, to leave the
// binary phase, to see the scan run off its range, and to show the result
// busy drops in the cycle the result is shown, so the next start can land there
// reset clears the entry count, the config bits and the controller; the key ram
// is not cleared, since rows at or above the entry count are never compared
module sorted_key_table_seek_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [skts_pkg::IN_KEY_W-1:0] i_key_value,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [0:0]                    i_cfg_data,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [skts_pkg::ROW_W-1:0]    o_row_index,
    output logic [skts_pkg::PROBE_W-1:0]  o_compare_count
);

    skts_pkg::t_dp_cmd  cmd;
    skts_pkg::t_dp_stat stat;
    logic               start_ok;

    // a start is only seen by the controller when the block is idle
    assign start_ok = start && !busy;

    skts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_ok),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    skts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_key_value     (i_key_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_row_index     (o_row_index),
        .o_compare_count (o_compare_count)
    );

`ifndef NO_ASSERTIONS
    // a taken transaction always makes the controller leave idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_ok |=> busy)
        else $error("accepted transaction did not raise busy");

    // the result strobe comes as the controller returns to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // a full-table append reports no row and no comparisons
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == skts_pkg::ST_FULL)) |->
            ((o_row_index == '0) && (o_compare_count == '0)))
        else $error("table full result carries row or count");

    // a miss reports row zero
    a_miss_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == skts_pkg::ST_NOT_FOUND)) |-> (o_row_index == '0))
        else $error("not found result carries a row");
`endif

endmodule

### tb/sorted_key_table_seek_core_test.sv
// self-checking testbench for the sorted key table seek core
`timescale 1ns / 1ps

module sorted_key_table_seek_core_test;

    // action and register codes that the package leaves unnamed
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    localparam logic [63:0] K_MAX   = '1;
    localparam logic [63:0] K_MIN_S = skts_pkg::KEY_SIGN;
    localparam logic [63:0] K_MAX_S = ~skts_pkg::KEY_SIGN;

    localparam int     RANDOM_ITEMS = 600;
    localparam longint RUN_LIMIT_NS = 30_000_000;

    // one transaction on the result side
    typedef struct packed {
        skts_pkg::t_status              status;
        logic [skts_pkg::ROW_W-1:0]     row;
        logic [skts_pkg::PROBE_W-1:0]   count;
    } t_seek_result;

    // one row of the directed plan: either a mode change or a transaction
    typedef struct packed {
        logic         mode_row;
        logic [2:0]   modes;      // {sequential, permissive, signed}
        logic [1:0]   act;
        logic [63:0]  key;
        logic         typed;      // want holds a hand-written result
        t_seek_result want;
    } t_plan_row;

    localparam t_seek_result NO_TYPED = '{skts_pkg::ST_OK, '0, '0};

    // directed part: empty table, unused code, corner keys in both orders,
    // permissive hits, sequential scan; typed results only where obvious
    localparam t_plan_row PLAN [28] = '{
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd0, 1'b1,
          '{skts_pkg::ST_NOT_FOUND, 10'd0, 11'd0}},
        '{1'b0, 3'b000, ACT_UNUSED, K_MAX, 1'b1, '{skts_pkg::ST_NOT_FOUND, 10'd0, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_CLEAR, K_MAX, 1'b1, '{skts_pkg::ST_OK, 10'd0, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, 64'd0, 1'b1, '{skts_pkg::ST_OK, 10'd0, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, 64'd1, 1'b1, '{skts_pkg::ST_OK, 10'd1, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, K_MAX_S, 1'b1, '{skts_pkg::ST_OK, 10'd2, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, K_MAX, 1'b1, '{skts_pkg::ST_OK, 10'd3, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd0, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, K_MAX, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd2, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, NO_TYPED},
        '{1'b1, 3'b010, skts_pkg::ACT_CLEAR, 64'd0, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd2, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, K_MIN_S, 1'b0, NO_TYPED},
        '{1'b1, 3'b001, skts_pkg::ACT_CLEAR, 64'd0, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_CLEAR, 64'd0, 1'b1, '{skts_pkg::ST_OK, 10'd0, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, K_MIN_S, 1'b1, '{skts_pkg::ST_OK, 10'd0, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, K_MAX, 1'b1, '{skts_pkg::ST_OK, 10'd1, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, 64'd0, 1'b1, '{skts_pkg::ST_OK, 10'd2, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, 64'd5, 1'b1, '{skts_pkg::ST_OK, 10'd3, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_APPEND, K_MAX_S, 1'b1, '{skts_pkg::ST_OK, 10'd4, 11'd0}},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, K_MIN_S, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, K_MAX_S, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd3, 1'b0, NO_TYPED},
        '{1'b1, 3'b111, skts_pkg::ACT_CLEAR, 64'd0, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, 64'd3, 1'b0, NO_TYPED},
        '{1'b0, 3'b000, skts_pkg::ACT_SEARCH, K_MAX_S, 1'b0, NO_TYPED},
        '{1'b1, 3'b000, skts_pkg::ACT_CLEAR, 64'd0, 1'b0, NO_TYPED}
    };

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         i_action;
    logic [skts_pkg::IN_KEY_W-1:0]      i_key_value;
    logic                               i_cfg_we;
    logic [1:0]                         i_cfg_index;
    logic [0:0]                         i_cfg_data;
    logic                               o_valid;
    logic [1:0]                         o_status;
    logic [skts_pkg::ROW_W-1:0]         o_row_index;
    logic [skts_pkg::PROBE_W-1:0]       o_compare_count;

    // shadow copy of the table and the mode bits
    logic [63:0]  model_keys [skts_pkg::TABLE_DEPTH];
    int           model_rows;
    logic         cfg_signed;
    logic         cfg_permissive;
    logic         cfg_sequential;

    t_seek_result expected_results [$];
    int           mismatches;
    int           results_seen;

    // stimulus shaping
    logic         steady;       // no idle cycles on the command side
    logic         narrow;       // keys drawn from a small window starting at key_base
    logic [63:0]  key_base;

    sorted_key_table_seek_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_key_value     (i_key_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_row_index     (o_row_index),
        .o_compare_count (o_compare_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns result %0d: %s", $time, results_seen, what);
    endtask

    // -1 stored key below target, 0 equal, 1 above; signed mode flips the sign bit
    function automatic int key_order(input logic [63:0] stored, input logic [63:0] target);
        logic [63:0] a;
        logic [63:0] b;
        a = stored;
        b = target;
        if (cfg_signed) begin
            a = a ^ skts_pkg::KEY_SIGN;
            b = b ^ skts_pkg::KEY_SIGN;
        end
        if (a < b)
            return -1;
        return (a > b) ? 1 : 0;
    endfunction

    // lower-bound seek: binary narrowing down to a short linear scan,
    // or a full linear scan in sequential mode
    function automatic t_seek_result seek_row(input logic [63:0] target);
        int           lo;
        int           hi;
        int           mid;
        int           c;
        t_seek_result r;
        r = '{skts_pkg::ST_NOT_FOUND, '0, '0};
        lo = 0;
        hi = model_rows;
        if (cfg_sequential) begin
            for (int i = 0; i < model_rows; i++) begin
                r.count = r.count + 1'b1;
                if (key_order(model_keys[i], target) == 0) begin
                    r.status = skts_pkg::ST_OK;
                    r.row = skts_pkg::ROW_W'(i);
                    return r;
                end
            end
            return r;
        end
        while (hi - lo > skts_pkg::SCAN_LIMIT) begin
            mid = (lo + hi) / 2;
            r.count = r.count + 1'b1;
            if (key_order(model_keys[mid], target) >= 0)
                hi = mid;
            else
                lo = mid;
        end
        for (int i = lo; i < hi; i++) begin
            r.count = r.count + 1'b1;
            c = key_order(model_keys[i], target);
            // exact hit, or first greater row when permissive
            if (c == 0 || (c > 0 && cfg_permissive)) begin
                r.status = skts_pkg::ST_OK;
                r.row = skts_pkg::ROW_W'(i);
                return r;
            end
            if (c > 0)
                return r;
        end
        // scan ran off its range: next row, unless that is the end of the table
        if (hi != model_rows) begin
            r.status = skts_pkg::ST_OK;
            r.row = skts_pkg::ROW_W'(hi);
        end
        return r;
    endfunction

    // applies one accepted transaction to the shadow table
    function automatic t_seek_result predict_seek(input logic [1:0] act, input logic [63:0] key);
        t_seek_result r;
        r = '{skts_pkg::ST_OK, '0, '0};
        case (act)
            skts_pkg::ACT_CLEAR: begin
                model_rows = 0;
            end
            skts_pkg::ACT_APPEND: begin
                if (model_rows >= skts_pkg::TABLE_DEPTH) begin
                    r.status = skts_pkg::ST_FULL;
                end else begin
                    model_keys[model_rows] = key;
                    r.row = skts_pkg::ROW_W'(model_rows);
                    model_rows++;
                end
            end
            skts_pkg::ACT_SEARCH: begin
                r = seek_row(key);
            end
            default: begin
                r.status = skts_pkg::ST_NOT_FOUND;
            end
        endcase
        return r;
    endfunction

    // one command transaction; start stays high across back-to-back items
    task automatic send_item(input logic [1:0] act, input logic [63:0] key,
                             output t_seek_result outcome);
        while (!steady && $urandom_range(99) < 23) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_key_value <= key;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        outcome = predict_seek(act, key);
    endtask

    task automatic issue(input logic [1:0] act, input logic [63:0] key);
        t_seek_result outcome;
        send_item(act, key, outcome);
        expected_results.push_back(outcome);
    endtask

    // wait until the block has delivered everything and is idle
    task automatic settle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // rewrites all three mode registers, now and then the spare index too
    task automatic set_modes(input logic sg, input logic pm, input logic sq);
        i_cfg_we <= 1'b1;
        i_cfg_index <= skts_pkg::CFG_SIGNED;
        i_cfg_data <= sg;
        @(posedge i_clk);
        i_cfg_index <= skts_pkg::CFG_PERMISSIVE;
        i_cfg_data <= pm;
        @(posedge i_clk);
        i_cfg_index <= skts_pkg::CFG_SEQUENTIAL;
        i_cfg_data <= sq;
        @(posedge i_clk);
        if ($urandom_range(3) == 0) begin
            i_cfg_index <= CFG_SPARE;
            i_cfg_data <= 1'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_signed = sg;
        cfg_permissive = pm;
        cfg_sequential = sq;
    endtask

    function automatic logic [63:0] fresh_key();
        if (narrow)
            return key_base + 64'($urandom_range(48));
        return {$urandom, $urandom};
    endfunction

    // search targets: stored keys, their neighbors, fresh keys and corners
    function automatic logic [63:0] choose_target();
        logic [63:0] k;
        int          pick;
        pick = $urandom_range(99);
        if (model_rows > 0 && pick < 40) begin
            k = model_keys[$urandom_range(model_rows - 1)];
        end else if (model_rows > 0 && pick < 60) begin
            k = model_keys[$urandom_range(model_rows - 1)];
            k = $urandom_range(1) ? k + 64'd1 : k - 64'd1;
        end else if (pick < 80) begin
            k = fresh_key();
        end else if (pick < 90) begin
            case ($urandom_range(3))
                0: k = '0;
                1: k = K_MAX;
                2: k = K_MIN_S;
                default: k = K_MAX_S;
            endcase
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    // appends count keys in the order of the current compare mode
    task automatic load_sorted(input int count);
        bit [63:0] order [$];
        bit [63:0] flip;
        flip = cfg_signed ? skts_pkg::KEY_SIGN : 64'd0;
        repeat (count) order.push_back(fresh_key() ^ flip);
        order.sort();
        foreach (order[i]) issue(skts_pkg::ACT_APPEND, order[i] ^ flip);
    endtask

    function automatic int phase_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(12);
        if (pick < 95)
            return $urandom_range(13, 64);
        return $urandom_range(65, 300);
    endfunction

    // result side: every strobe must match the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_seek_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_row_index !== want.row)
                    report_mismatch($sformatf("row %0d, expected %0d",
                                              o_row_index, want.row));
                if (o_compare_count !== want.count)
                    report_mismatch($sformatf("compare count %0d, expected %0d",
                                              o_compare_count, want.count));
            end
        end
    end

    initial begin : stimulus
        t_seek_result got;
        int           rand_items;
        int           n;
        int           m;

        mismatches = 0;
        results_seen = 0;
        model_rows = 0;
        cfg_signed = 1'b0;
        cfg_permissive = 1'b0;
        cfg_sequential = 1'b0;
        steady = 1'b0;
        narrow = 1'b0;
        key_base = '0;
        rand_items = 0;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_action <= skts_pkg::ACT_CLEAR;
        i_key_value <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= skts_pkg::CFG_SIGNED;
        i_cfg_data <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        foreach (PLAN[i]) begin
            if (PLAN[i].mode_row) begin
                settle();
                set_modes(PLAN[i].modes[0], PLAN[i].modes[1], PLAN[i].modes[2]);
            end else begin
                send_item(PLAN[i].act, PLAN[i].key, got);
                expected_results.push_back(PLAN[i].typed ? PLAN[i].want : got);
            end
        end

        // random phases: mostly clear, sorted load, then searches
        while (rand_items < RANDOM_ITEMS) begin
            steady = (rand_items >= 150 && rand_items < 300);

            settle();
            set_modes(1'($urandom), 1'($urandom), $urandom_range(99) < 30);
            narrow = 1'($urandom);
            case ($urandom_range(3))
                0: key_base = {$urandom, $urandom};
                1: key_base = '0;
                2: key_base = K_MIN_S - 64'd24;
                default: key_base = K_MAX - 64'd24;
            endcase

            if ($urandom_range(99) < 85) begin
                n = phase_size();
                m = $urandom_range(4, 12);
                issue(skts_pkg::ACT_CLEAR, {$urandom, $urandom});
                load_sorted(n);
                repeat (m) issue(skts_pkg::ACT_SEARCH, choose_target());
                rand_items += 1 + n + m;
            end else begin
                // noise: any action code, unsorted keys
                m = $urandom_range(6, 15);
                repeat (m) issue(2'($urandom_range(3)), {$urandom, $urandom});
                rand_items += m;
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
